// ----- design/assert_macros.svh -----
// Assertion helpers for the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every edge, held off while reset is asserted.
`define GFPIP_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Property checked at every edge, reset included.
`define GFPIP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- design/gfpip_pkg.sv -----
package gfpip_pkg;

    localparam int MAX_VERTICES = 256;
    localparam int ADDR_W       = $clog2(MAX_VERTICES);
    localparam int COUNT_W      = 8;
    localparam int COORD_W      = 32;
    localparam int DIFF_W       = COORD_W + 1;
    localparam int PROD_W       = 2 * DIFF_W;
    localparam int STATUS_W     = 2;

    localparam logic signed [COORD_W-1:0] LAT_LIMIT = 32'sd900000000;
    localparam logic signed [COORD_W-1:0] LNG_LIMIT = 32'sd1800000000;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [STATUS_W-1:0] ST_IN_BOUNDS     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OUT_OF_BOUNDS = 2'd1;
    localparam logic [STATUS_W-1:0] ST_INVALID_POINT = 2'd2;
    localparam logic [STATUS_W-1:0] ST_INVALID_POLY  = 2'd3;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DRAIN,
        S_DONE
    } t_state;

    typedef struct packed {
        logic signed [COORD_W-1:0] lat;
        logic signed [COORD_W-1:0] lng;
    } t_vertex;

    typedef struct packed {
        logic busy;
        logic vld;
        logic flip;
        logic bad;
    } t_edge_res;

    function automatic logic coord_ok(input logic signed [COORD_W-1:0] lat,
                                      input logic signed [COORD_W-1:0] lng);
        return (lat >= -LAT_LIMIT) && (lat <= LAT_LIMIT) &&
               (lng >= -LNG_LIMIT) && (lng <= LNG_LIMIT);
    endfunction

    function automatic logic signed [DIFF_W-1:0] sx(input logic signed [COORD_W-1:0] v);
        return DIFF_W'(v);
    endfunction

endpackage

// ----- design/geofence_point_in_polygon.sv -----
// Geofence point-in-polygon checker.
// Input channel (i_valid / o_ready) carries one transaction per item: opcode 0
// stores a vertex (latitude, longitude) at i_vertex_index and gives no result;
// opcode 1 queries a point and gives one o_status on the output channel
// (o_valid / i_ready). i_cfg_wr_en with i_cfg_wr_data sets the vertex count;
// write it only while the block is idle.
// A query with an out-of-range point or an empty polygon skips the vertex
// walk and goes straight to the done state. Otherwise the query reads the
// vertex memory once per cycle through its single read port, vertex_count + 1
// reads, followed by a drain of the read and cross-multiply pipeline, with one
// query in flight at a time.
// Synchronous active-low reset clears the vertex count to zero, empties the
// output register and returns to idle; vertex memory is not cleared, so every
// vertex in use must be written before it is queried.
// A finished status sits in an output register; while the receiver stalls, the
// block still takes vertex writes but holds a further query result until the
// register frees.
module geofence_point_in_polygon (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    output logic                                   o_ready,
    input  logic                                   i_opcode,
    input  logic [gfpip_pkg::ADDR_W-1:0]           i_vertex_index,
    input  logic signed [gfpip_pkg::COORD_W-1:0]   i_latitude,
    input  logic signed [gfpip_pkg::COORD_W-1:0]   i_longitude,
    output logic                                   o_valid,
    input  logic                                   i_ready,
    output logic [gfpip_pkg::STATUS_W-1:0]         o_status,
    input  logic                                   i_cfg_wr_en,
    input  logic [gfpip_pkg::COUNT_W-1:0]          i_cfg_wr_data
);

    gfpip_pkg::t_state r_state, n_state;

    logic [gfpip_pkg::COUNT_W-1:0]         r_vertex_count;
    logic signed [gfpip_pkg::COORD_W-1:0]  r_plat, r_plng;
    logic [gfpip_pkg::ADDR_W-1:0]          r_idx;
    logic                                  r_first;
    logic                                  r_rd_vld, r_rd_prime;
    logic                                  r_inside, r_bad;
    logic [gfpip_pkg::STATUS_W-1:0]        r_status;
    logic                                  r_out_vld;
    logic [gfpip_pkg::STATUS_W-1:0]        r_out_status;

    logic accept, accept_query, accept_write, point_ok;
    logic rd_issue, last_issue, drain_done, out_load;
    logic [gfpip_pkg::ADDR_W-1:0] rd_addr, last_addr;

    gfpip_pkg::t_vertex   wr_vtx, rd_vtx;
    gfpip_pkg::t_edge_res edge_res;

    assign accept       = i_valid && o_ready;
    assign accept_query = accept && (i_opcode == gfpip_pkg::OP_QUERY);
    assign accept_write = accept && (i_opcode == gfpip_pkg::OP_WRITE);
    assign point_ok     = gfpip_pkg::coord_ok(i_latitude, i_longitude);
    assign last_addr    = gfpip_pkg::ADDR_W'(r_vertex_count - 1'b1);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            gfpip_pkg::S_IDLE: begin
                if (accept_query) begin
                    if (!point_ok || (r_vertex_count == '0)) begin
                        n_state = gfpip_pkg::S_DONE;
                    end else begin
                        n_state = gfpip_pkg::S_RUN;
                    end
                end
            end
            gfpip_pkg::S_RUN: begin
                if (last_issue) begin
                    n_state = gfpip_pkg::S_DRAIN;
                end
            end
            gfpip_pkg::S_DRAIN: begin
                if (drain_done) begin
                    n_state = gfpip_pkg::S_DONE;
                end
            end
            gfpip_pkg::S_DONE: begin
                if (out_load) begin
                    n_state = gfpip_pkg::S_IDLE;
                end
            end
            default: n_state = gfpip_pkg::S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_ready    = 1'b0;
        rd_issue   = 1'b0;
        drain_done = 1'b0;
        out_load   = 1'b0;
        unique case (r_state)
            gfpip_pkg::S_IDLE:  o_ready    = 1'b1;
            gfpip_pkg::S_RUN:   rd_issue   = 1'b1;
            gfpip_pkg::S_DRAIN: drain_done = !r_rd_vld && !edge_res.busy;
            gfpip_pkg::S_DONE:  out_load   = !r_out_vld || i_ready;
            default: ;
        endcase
    end

    assign last_issue = rd_issue && !r_first && (r_idx == last_addr);
    // prime the previous-vertex register with the closing vertex first
    assign rd_addr    = r_first ? last_addr : r_idx;

    assign wr_vtx.lat = i_latitude;
    assign wr_vtx.lng = i_longitude;

    gfpip_vertex_mem u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (accept_write),
        .i_wr_addr (i_vertex_index),
        .i_wr_data (wr_vtx),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_vtx)
    );

    gfpip_edge_unit u_edge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_rd_vld),
        .i_prime (r_rd_prime),
        .i_vtx   (rd_vtx),
        .i_plat  (r_plat),
        .i_plng  (r_plng),
        .o_res   (edge_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= gfpip_pkg::S_IDLE;
            r_vertex_count <= '0;
            r_rd_vld       <= 1'b0;
            r_rd_prime     <= 1'b0;
            r_out_vld      <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_rd_vld   <= rd_issue;
            r_rd_prime <= rd_issue && r_first;
            if (i_cfg_wr_en) begin
                r_vertex_count <= i_cfg_wr_data;
            end
            if (out_load) begin
                r_out_vld <= 1'b1;
            end else if (i_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept_query) begin
            r_plat   <= i_latitude;
            r_plng   <= i_longitude;
            r_first  <= 1'b1;
            r_idx    <= '0;
            r_inside <= 1'b0;
            r_bad    <= 1'b0;
            r_status <= point_ok ? gfpip_pkg::ST_IN_BOUNDS : gfpip_pkg::ST_INVALID_POINT;
        end else begin
            if (rd_issue) begin
                r_first <= 1'b0;
                if (!r_first) begin
                    r_idx <= r_idx + 1'b1;
                end
            end
            if (edge_res.vld) begin
                r_inside <= r_inside ^ edge_res.flip;
                r_bad    <= r_bad | edge_res.bad;
            end
            if (drain_done) begin
                r_status <= r_bad    ? gfpip_pkg::ST_INVALID_POLY :
                            r_inside ? gfpip_pkg::ST_IN_BOUNDS    :
                                       gfpip_pkg::ST_OUT_OF_BOUNDS;
            end
        end
        if (out_load) begin
            r_out_status <= r_status;
        end
    end

    assign o_valid  = r_out_vld;
    assign o_status = r_out_status;

endmodule

// ----- design/gfpip_vertex_mem.sv -----
module gfpip_vertex_mem (
    input  logic                         i_clk,
    input  logic                         i_wr_en,
    input  logic [gfpip_pkg::ADDR_W-1:0] i_wr_addr,
    input  gfpip_pkg::t_vertex           i_wr_data,
    input  logic [gfpip_pkg::ADDR_W-1:0] i_rd_addr,
    output gfpip_pkg::t_vertex           o_rd_data
);

    gfpip_pkg::t_vertex mem [gfpip_pkg::MAX_VERTICES];
    gfpip_pkg::t_vertex r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- design/gfpip_edge_unit.sv -----
module gfpip_edge_unit (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_vld,
    input  logic                                      i_prime,
    input  gfpip_pkg::t_vertex                        i_vtx,
    input  logic signed [gfpip_pkg::COORD_W-1:0]      i_plat,
    input  logic signed [gfpip_pkg::COORD_W-1:0]      i_plng,
    output gfpip_pkg::t_edge_res                      o_res
);

    gfpip_pkg::t_vertex r_prev;

    logic r_s1_vld, r_s2_vld;
    logic r_s1_cross, r_s1_dpos, r_s1_bad;
    logic r_s2_cross, r_s2_dpos, r_s2_bad;
    logic signed [gfpip_pkg::DIFF_W-1:0] r_a, r_b, r_c, r_d;
    logic signed [gfpip_pkg::PROD_W-1:0] r_lhs, r_rhs;

    logic signed [gfpip_pkg::COORD_W-1:0] ilat, ilng, jlat, jlng;
    logic straddle;

    assign ilat = i_vtx.lat;
    assign ilng = i_vtx.lng;
    assign jlat = r_prev.lat;
    assign jlng = r_prev.lng;

    assign straddle = ((ilng < i_plng) && (jlng >= i_plng)) ||
                      ((jlng < i_plng) && (ilng >= i_plng));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
        end else begin
            r_s1_vld <= i_vld && !i_prime;
            r_s2_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_vld) begin
            r_prev <= i_vtx;
        end
        // stage 1: differences and edge classification
        r_a        <= gfpip_pkg::sx(i_plng) - gfpip_pkg::sx(ilng);
        r_b        <= gfpip_pkg::sx(jlat) - gfpip_pkg::sx(ilat);
        r_c        <= gfpip_pkg::sx(i_plat) - gfpip_pkg::sx(ilat);
        r_d        <= gfpip_pkg::sx(jlng) - gfpip_pkg::sx(ilng);
        r_s1_cross <= straddle;
        r_s1_dpos  <= jlng > ilng;
        r_s1_bad   <= !gfpip_pkg::coord_ok(ilat, ilng);
        // stage 2: cross-multiply
        r_lhs      <= r_a * r_b;
        r_rhs      <= r_c * r_d;
        r_s2_cross <= r_s1_cross;
        r_s2_dpos  <= r_s1_dpos;
        r_s2_bad   <= r_s1_bad;
    end

    always_comb begin
        o_res.busy = r_s1_vld || r_s2_vld;
        o_res.vld  = r_s2_vld;
        o_res.bad  = r_s2_bad;
        // flip the sense of the compare for edges running toward lower longitude
        o_res.flip = r_s2_cross && (r_s2_dpos ? (r_lhs < r_rhs) : (r_lhs > r_rhs));
    end

endmodule

// ----- design/gfpip_checker.sv -----
`include "assert_macros.svh"

module gfpip_checker (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 i_valid,
    input logic                                 o_ready,
    input logic                                 i_opcode,
    input logic                                 o_valid,
    input logic                                 i_ready,
    input logic [gfpip_pkg::STATUS_W-1:0]       o_status
);

    `GFPIP_ASSERT_ALWAYS(a_reset_empties_out, i_clk, !i_rst_n |=> !o_valid, "result after reset")

    `GFPIP_ASSERT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready |=> o_valid && $stable(o_status), "stalled result changed")

    `GFPIP_ASSERT(a_query_busy, i_clk, i_rst_n, i_valid && o_ready && (i_opcode == gfpip_pkg::OP_QUERY) |=> !o_ready, "ready held after query")

    `GFPIP_ASSERT(a_write_no_result, i_clk, i_rst_n, i_valid && o_ready && (i_opcode == gfpip_pkg::OP_WRITE) && !o_valid |=> !o_valid, "write produced a result")

endmodule

bind geofence_point_in_polygon gfpip_checker u_gfpip_checker (.*);

// ----- bench/geofence_point_in_polygon_tb.sv -----
`timescale 1ns / 100ps

module geofence_point_in_polygon_tb;
    import gfpip_pkg::*;

    typedef logic signed [COORD_W-1:0] coord_t;

    typedef enum logic [1:0] {
        ROW_WRITE,
        ROW_QUERY,
        ROW_SIZE
    } row_kind_t;

    typedef struct packed {
        row_kind_t             kind;
        logic [ADDR_W-1:0]     arg;     // slot for a write, vertex count for a resize
        coord_t                lat;
        coord_t                lng;
        logic                  known;
        logic [STATUS_W-1:0]   status;
    } fence_row_t;

    localparam int DIR_ROWS    = 26;
    localparam int RAND_ITEMS  = 1800;
    localparam int IDLE_PCT    = 27;
    localparam int CYCLE_LIMIT = 400000;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_valid;
    logic                  o_ready;
    logic                  i_opcode;
    logic [ADDR_W-1:0]     i_vertex_index;
    coord_t                i_latitude;
    coord_t                i_longitude;
    logic                  o_valid;
    logic                  i_ready;
    logic [STATUS_W-1:0]   o_status;
    logic                  i_cfg_wr_en;
    logic [COUNT_W-1:0]    i_cfg_wr_data;

    // Mirror of the polygon held by the block
    coord_t                fence_lat [MAX_VERTICES];
    coord_t                fence_lng [MAX_VERTICES];
    bit                    slot_written [MAX_VERTICES];
    int                    fence_size = 0;

    logic [STATUS_W-1:0]   pending_status [$];
    int                    fail_count = 0;
    int                    cycle_count = 0;
    bit                    steady = 1'b0;

    // Region that the current phase draws vertices and points from
    longint                ctr_lat, ctr_lng, rad_lat, rad_lng;
    int                    bad_pct = 0;

    fence_row_t            dir_rows [DIR_ROWS];

    geofence_point_in_polygon dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_opcode       (i_opcode),
        .i_vertex_index (i_vertex_index),
        .i_latitude     (i_latitude),
        .i_longitude    (i_longitude),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_status       (o_status),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic logic coord_in_range(input coord_t lat, input coord_t lng);
        return (lat >= -LAT_LIMIT) && (lat <= LAT_LIMIT) &&
               (lng >= -LNG_LIMIT) && (lng <= LNG_LIMIT);
    endfunction

    // Even-odd crossing count with the exact cross-multiply compare
    function automatic logic [STATUS_W-1:0] fence_status(input coord_t plat, input coord_t plng);
        int                         prev;
        logic                       odd;
        logic signed [DIFF_W-1:0]   ilat, ilng, jlat, jlng, pl, pg, run;
        logic signed [PROD_W-1:0]   lhs, rhs;
        if (!coord_in_range(plat, plng))
            return ST_INVALID_POINT;
        if (fence_size == 0)
            return ST_IN_BOUNDS;
        for (int k = 0; k < fence_size; k++)
            if (!coord_in_range(fence_lat[k], fence_lng[k]))
                return ST_INVALID_POLY;
        odd = 1'b0;
        prev = fence_size - 1;
        pl = plat;
        pg = plng;
        for (int k = 0; k < fence_size; k++) begin
            if ((fence_lng[k] < plng) != (fence_lng[prev] < plng)) begin
                ilat = fence_lat[k];
                ilng = fence_lng[k];
                jlat = fence_lat[prev];
                jlng = fence_lng[prev];
                run = jlng - ilng;
                lhs = (pg - ilng) * (jlat - ilat);
                rhs = (pl - ilat) * run;
                // flip the compare when the edge runs toward lower longitude
                if ((run > 0) ? (lhs < rhs) : (lhs > rhs))
                    odd = ~odd;
            end
            prev = k;
        end
        return odd ? ST_IN_BOUNDS : ST_OUT_OF_BOUNDS;
    endfunction

    function automatic coord_t pick_coord(input longint lo, input longint hi);
        longint unsigned span;
        longint unsigned raw;
        if (lo < -64'sd2147483648)
            lo = -64'sd2147483648;
        if (hi > 64'sd2147483647)
            hi = 64'sd2147483647;
        span = longint'(hi - lo + 1);
        raw = {$urandom, $urandom};
        return coord_t'(lo + longint'(raw % span));
    endfunction

    function automatic void pick_vertex(output coord_t lat, output coord_t lng);
        if ($urandom_range(99) < bad_pct) begin
            lat = $urandom;
            lng = $urandom;
        end else begin
            lat = pick_coord(ctr_lat - rad_lat, ctr_lat + rad_lat);
            lng = pick_coord(ctr_lng - rad_lng, ctr_lng + rad_lng);
        end
    endfunction

    task automatic send_item(input logic op, input logic [ADDR_W-1:0] slot,
                             input coord_t lat, input coord_t lng,
                             input logic known, input logic [STATUS_W-1:0] status);
        if (!steady && $urandom_range(99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < IDLE_PCT);
        end
        i_valid        <= 1'b1;
        i_opcode       <= op;
        i_vertex_index <= slot;
        i_latitude     <= lat;
        i_longitude    <= lng;
        do @(posedge i_clk); while (!o_ready);
        // transaction taken at this edge
        if (op == OP_WRITE) begin
            fence_lat[slot]    = lat;
            fence_lng[slot]    = lng;
            slot_written[slot] = 1'b1;
        end else begin
            pending_status.push_back(known ? status : fence_status(lat, lng));
        end
    endtask

    task automatic set_fence_size(input int n);
        i_valid <= 1'b0;
        while (pending_status.size() != 0)
            @(posedge i_clk);
        // let a trailing write or the last walk settle
        repeat (fence_size + 8) @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= COUNT_W'(n);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        fence_size = n;
    endtask

    initial begin
        logic [STATUS_W-1:0] want;
        i_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && i_ready) begin
                if (pending_status.size() == 0) begin
                    $error("status: expected none, got %0d", o_status);
                    fail_count++;
                end else begin
                    want = pending_status.pop_front();
                    if (o_status !== want) begin
                        $error("status: expected %0d, got %0d", want, o_status);
                        fail_count++;
                    end
                end
            end
            i_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    initial begin
        int     items;
        int     phase;
        int     n;
        int     queries;
        int     slot;
        int     pick;
        coord_t plat, plng, vlat, vlng;

        dir_rows = '{
            '{ROW_QUERY, 8'd0,   32'sd0,               32'sd0,               1'b1, ST_IN_BOUNDS},
            '{ROW_QUERY, 8'd0,   LAT_LIMIT + 32'sd1,   32'sd0,               1'b1, ST_INVALID_POINT},
            '{ROW_QUERY, 8'd0,   32'sh8000_0000,       32'sd0,               1'b1, ST_INVALID_POINT},
            '{ROW_QUERY, 8'd0,   32'sd0,               -LNG_LIMIT - 32'sd1,  1'b1, ST_INVALID_POINT},
            '{ROW_QUERY, 8'd0,   32'sd0,               32'sh7FFF_FFFF,       1'b1, ST_INVALID_POINT},
            '{ROW_QUERY, 8'd0,   LAT_LIMIT,            -LNG_LIMIT,           1'b1, ST_IN_BOUNDS},
            '{ROW_WRITE, 8'd0,   -32'sd1000,           -32'sd1000,           1'b0, ST_IN_BOUNDS},
            '{ROW_WRITE, 8'd1,   -32'sd1000,           32'sd1000,            1'b0, ST_IN_BOUNDS},
            '{ROW_WRITE, 8'd2,   32'sd1000,            32'sd1000,            1'b0, ST_IN_BOUNDS},
            '{ROW_WRITE, 8'd3,   32'sd1000,            -32'sd1000,           1'b0, ST_IN_BOUNDS},
            '{ROW_SIZE,  8'd4,   32'sd0,               32'sd0,               1'b0, ST_IN_BOUNDS},
            '{ROW_QUERY, 8'd0,   32'sd0,               32'sd0,               1'b0, ST_IN_BOUNDS},
            '{ROW_QUERY, 8'd0,   32'sd2000,            32'sd0,               1'b0, ST_IN_BOUNDS},
            '{ROW_QUERY, 8'd0,   32'sd0,               -32'sd1000,           1'b0, ST_IN_BOUNDS},
            '{ROW_QUERY, 8'd0,   -LAT_LIMIT - 32'sd1,  32'sd0,               1'b1, ST_INVALID_POINT},
            '{ROW_WRITE, 8'd255, -LAT_LIMIT,           -LNG_LIMIT,           1'b0, ST_IN_BOUNDS},
            '{ROW_WRITE, 8'd4,   LAT_LIMIT + 32'sd1,   32'sd0,               1'b0, ST_IN_BOUNDS},
            '{ROW_SIZE,  8'd5,   32'sd0,               32'sd0,               1'b0, ST_IN_BOUNDS},
            '{ROW_QUERY, 8'd0,   32'sd0,               32'sd0,               1'b1, ST_INVALID_POLY},
            '{ROW_QUERY, 8'd0,   32'sd0,               LNG_LIMIT + 32'sd1,   1'b1, ST_INVALID_POINT},
            '{ROW_WRITE, 8'd4,   32'sh8000_0000,       32'sh7FFF_FFFF,       1'b0, ST_IN_BOUNDS},
            '{ROW_QUERY, 8'd0,   32'sd500,             32'sd500,             1'b1, ST_INVALID_POLY},
            '{ROW_WRITE, 8'd4,   LAT_LIMIT,            LNG_LIMIT,            1'b0, ST_IN_BOUNDS},
            '{ROW_QUERY, 8'd0,   LAT_LIMIT,            LNG_LIMIT,            1'b0, ST_IN_BOUNDS},
            '{ROW_QUERY, 8'd0,   -LAT_LIMIT,           -LNG_LIMIT,           1'b0, ST_IN_BOUNDS},
            '{ROW_QUERY, 8'd0,   32'sd0,               32'sd500,             1'b0, ST_IN_BOUNDS}
        };

        i_rst_n        <= 1'b0;
        i_valid        <= 1'b0;
        i_opcode       <= OP_WRITE;
        i_vertex_index <= '0;
        i_latitude     <= '0;
        i_longitude    <= '0;
        i_cfg_wr_en    <= 1'b0;
        i_cfg_wr_data  <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[r]) begin
            case (dir_rows[r].kind)
                ROW_WRITE: send_item(OP_WRITE, dir_rows[r].arg, dir_rows[r].lat,
                                     dir_rows[r].lng, 1'b0, ST_IN_BOUNDS);
                ROW_QUERY: send_item(OP_QUERY, dir_rows[r].arg, dir_rows[r].lat,
                                     dir_rows[r].lng, dir_rows[r].known, dir_rows[r].status);
                default:   set_fence_size(int'(dir_rows[r].arg));
            endcase
        end

        items = 0;
        phase = 0;
        while (items < RAND_ITEMS) begin
            steady = (phase >= 10 && phase < 18);
            if (phase % 24 == 5) begin
                n = MAX_VERTICES - 1;
            end else begin
                case ($urandom_range(9))
                    0:       n = 0;
                    1:       n = $urandom_range(3, 1);
                    default: n = $urandom_range(24, 3);
                endcase
            end
            case ($urandom_range(9))
                0, 1, 2: begin
                    ctr_lat = 0;
                    ctr_lng = 0;
                    rad_lat = LAT_LIMIT;
                    rad_lng = LNG_LIMIT;
                end
                default: begin
                    // tiny regions make shared longitudes likely
                    rad_lat = ($urandom_range(3) == 0) ? $urandom_range(8, 1)
                                                       : $urandom_range(2000000, 10);
                    rad_lng = 2 * rad_lat;
                    ctr_lat = pick_coord(-LAT_LIMIT, LAT_LIMIT);
                    ctr_lng = pick_coord(-LNG_LIMIT, LNG_LIMIT);
                end
            endcase
            bad_pct = ($urandom_range(7) == 0) ? 10 : 0;
            set_fence_size(n);

            for (int s = 0; s < n; s++) begin
                if (n <= 32 || !slot_written[s] || !coord_in_range(fence_lat[s], fence_lng[s]) ||
                    $urandom_range(15) == 0) begin
                    pick_vertex(vlat, vlng);
                    send_item(OP_WRITE, ADDR_W'(s), vlat, vlng, 1'b0, ST_IN_BOUNDS);
                    items++;
                end
            end

            queries = (n == MAX_VERTICES - 1) ? 3 : $urandom_range(30, 6);
            while (queries > 0) begin
                if ($urandom_range(99) < 12) begin
                    // move a live vertex, or scribble on a slot outside the polygon
                    if (n > 0 && $urandom_range(1) == 0) begin
                        slot = $urandom_range(n - 1);
                        pick_vertex(vlat, vlng);
                    end else begin
                        slot = $urandom_range(MAX_VERTICES - 1, n);
                        vlat = $urandom;
                        vlng = $urandom;
                    end
                    send_item(OP_WRITE, ADDR_W'(slot), vlat, vlng, 1'b0, ST_IN_BOUNDS);
                end else begin
                    pick = $urandom_range(19);
                    plat = pick_coord(ctr_lat - rad_lat - rad_lat / 4,
                                      ctr_lat + rad_lat + rad_lat / 4);
                    plng = pick_coord(ctr_lng - rad_lng - rad_lng / 4,
                                      ctr_lng + rad_lng + rad_lng / 4);
                    if (pick >= 11 && pick <= 14 && n > 0) begin
                        slot = $urandom_range(n - 1);
                        plng = fence_lng[slot];
                        if (pick == 14)
                            plat = fence_lat[slot];
                    end else if (pick == 15 || pick == 16) begin
                        plat = $urandom;
                        plng = $urandom;
                    end else if (pick == 17) begin
                        plat = pick_coord(LAT_LIMIT, LAT_LIMIT + 1);
                        if ($urandom_range(1) == 1)
                            plat = -plat;
                    end else if (pick == 18) begin
                        plng = pick_coord(LNG_LIMIT, LNG_LIMIT + 1);
                        if ($urandom_range(1) == 1)
                            plng = -plng;
                    end else if (pick == 19) begin
                        plat = pick_coord(-LAT_LIMIT, LAT_LIMIT);
                        plng = pick_coord(-LNG_LIMIT, LNG_LIMIT);
                    end
                    send_item(OP_QUERY, ADDR_W'($urandom), plat, plng, 1'b0, ST_IN_BOUNDS);
                    queries--;
                end
                items++;
            end
            phase++;
        end

        steady = 1'b0;
        i_valid <= 1'b0;
        while (pending_status.size() != 0)
            @(posedge i_clk);
        repeat (fence_size + 16) @(posedge i_clk);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
